// ===== sv/chps_pkg.sv =====
// Shared types and constants for the channel histogram with peak scaling.
// Holds the item structs, mode codes, register indexes and defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package chps_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_BIN_COUNT  = 256;
  localparam int DEF_CHANNELS   = 3;
  localparam int DEF_COUNT_BITS = 24;

  // Fixed field geometry of the result beat.
  localparam int REPORTED  = 3;
  localparam int CNT_OUT_W = 24;
  localparam int HEIGHT_W  = 10;
  localparam int CHAN_W    = 2;

  // Item modes.
  localparam logic [1:0] MODE_PIXEL = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // Register indexes, taken from the word address.
  localparam logic REG_CHANNEL_COUNT = 1'b0;
  localparam logic REG_CANVAS_HEIGHT = 1'b1;

  localparam logic [CHAN_W-1:0]   RST_CHANNEL_COUNT = 2'd3;
  localparam logic [HEIGHT_W-1:0] RST_CANVAS_HEIGHT = 10'd125;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] sample_0;
    logic [7:0] sample_1;
    logic [7:0] sample_2;
    logic [7:0] query_bin;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           bin_index;
    logic [CNT_OUT_W-1:0] count_0;
    logic [CNT_OUT_W-1:0] count_1;
    logic [CNT_OUT_W-1:0] count_2;
    logic [HEIGHT_W-1:0]  height_0;
    logic [HEIGHT_W-1:0]  height_1;
    logic [HEIGHT_W-1:0]  height_2;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/chps_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module chps_ram #(
  parameter int  WIDTH = 24,
  parameter int  DEPTH = 768,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/chps_div.sv =====
// Restoring divider that yields one quotient bit per cycle.
// The quotient must fit in QUOT_W bits; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module chps_div #(
  parameter int  DIVISOR_W = 24,
  parameter int  QUOT_W    = 10,
  localparam int REM_W     = DIVISOR_W + QUOT_W,
  localparam int STEP_W    = $clog2(QUOT_W + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [REM_W-1:0]     dividend,
  input  wire logic [DIVISOR_W-1:0] divisor,
  output logic                      done,
  output logic      [QUOT_W-1:0]    quotient
);

  logic              run_r,  run_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [REM_W-1:0]  rem_r,  rem_nxt;
  logic [REM_W-1:0]  dsh_r,  dsh_nxt;
  logic [QUOT_W-1:0] quot_r, quot_nxt;
  logic [REM_W:0]    diff;
  logic              fits;

  always_comb begin
    diff     = {1'b0, rem_r} - {1'b0, dsh_r};
    fits     = !diff[REM_W];
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quot_nxt = quot_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = STEP_W'(QUOT_W);
      rem_nxt  = dividend;
      dsh_nxt  = REM_W'(divisor) << (QUOT_W - 1);
      quot_nxt = '0;
    end else if (run_r) begin
      if (fits) begin
        rem_nxt = diff[REM_W-1:0];
      end
      quot_nxt = {quot_r[QUOT_W-2:0], fits};
      dsh_nxt  = dsh_r >> 1;
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quot_r <= quot_nxt;
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

`default_nettype wire

// ===== sv/channel_histogram_with_peak_scale_core.sv =====
// Top level of the per-channel intensity histogram with peak-scaled bar heights.
// Depends on chps_pkg, chps_ram (count store) and chps_div (height divider).
//
//   Channel   Handshake              Payload        Direction
//   input     start / busy           in_data        in
//   result    out_valid (strobe)     out_data       out
//   config    psel/penable/pwrite    paddr, pwdata  in (prdata out)
//
// A pixel beat keeps busy high while each active channel passes through
// ST_PX_RD and ST_PX_WR for the read-modify-write of its count in the count
// RAM, and each inactive channel through ST_PX_RD only.
// A query beat keeps busy high while each channel passes through ST_Q_RD,
// ST_Q_CNT and ST_Q_GO, plus ST_Q_DIV for an active channel with a nonzero peak,
// in which the shared restoring divider makes one height bit per cycle; ST_Q_OUT
// then loads the result. The strobe follows in the next cycle, in which a new beat
// may already be taken.
// A clear beat, and reset, sweep the count RAM one entry a cycle, covering all
// min(CHANNELS,3)*BIN_COUNT entries (768 by default) with busy high.
// The result strobe lasts one cycle and cannot be held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module channel_histogram_with_peak_scale_core
  import chps_pkg::*;
#(
  parameter int BIN_COUNT  = DEF_BIN_COUNT,
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Item channel
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_data,
  // Result channel
  output logic             out_valid,
  output out_item_t        out_data,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  // Only the first three channels are ever active, so only they get storage.
  localparam int USED_CH = (CHANNELS < REPORTED) ? CHANNELS : REPORTED;
  localparam int DEPTH   = USED_CH * BIN_COUNT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int PROD_W  = COUNT_BITS + HEIGHT_W;
  localparam int EXT_W   = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLR   = 4'd1;
  localparam logic [3:0] ST_PX_RD = 4'd2;
  localparam logic [3:0] ST_PX_WR = 4'd3;
  localparam logic [3:0] ST_Q_RD  = 4'd4;
  localparam logic [3:0] ST_Q_CNT = 4'd5;
  localparam logic [3:0] ST_Q_GO  = 4'd6;
  localparam logic [3:0] ST_Q_DIV = 4'd7;
  localparam logic [3:0] ST_Q_OUT = 4'd8;

  logic [3:0]            state_r,    state_nxt;
  logic [CHAN_W-1:0]     ch_r,       ch_nxt;
  logic [ADDR_W-1:0]     clr_addr_r, clr_addr_nxt;
  in_item_t              in_r,       in_nxt;
  logic [CHAN_W-1:0]     chan_cnt_r;
  logic [HEIGHT_W-1:0]   canvas_r;
  logic [COUNT_BITS-1:0] peak_r     [REPORTED];
  logic [COUNT_BITS-1:0] peak_nxt   [REPORTED];
  logic [CNT_OUT_W-1:0]  count_r    [REPORTED];
  logic [CNT_OUT_W-1:0]  count_nxt  [REPORTED];
  logic [HEIGHT_W-1:0]   height_r   [REPORTED];
  logic [HEIGHT_W-1:0]   height_nxt [REPORTED];
  logic [PROD_W-1:0]     prod_r,     prod_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r,      out_nxt;

  // Count store and divider hookup.
  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;
  logic                  div_start, div_done;
  logic [HEIGHT_W-1:0]   div_quot;

  // Per-channel decode of the item held in in_r.
  logic [7:0]            cur_bin;
  logic                  ch_on;
  logic                  act;
  logic [ADDR_W-1:0]     cur_addr;
  logic [COUNT_BITS-1:0] inc_val;
  logic [COUNT_BITS-1:0] cnt_full;
  logic [EXT_W-1:0]      cnt_ext;
  logic                  accept;
  logic                  cfg_wr;
  logic                  last_ch;

  chps_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cur_addr),
    .rdata (ram_rdata)
  );

  chps_div #(
    .DIVISOR_W (COUNT_BITS),
    .QUOT_W    (HEIGHT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (peak_r[ch_r]),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // The sample or query bin that belongs to the channel now in turn.
  always_comb begin
    if (in_r.mode == MODE_QUERY) begin
      cur_bin = in_r.query_bin;
    end else begin
      case (ch_r)
        2'd0:    cur_bin = in_r.sample_0;
        2'd1:    cur_bin = in_r.sample_1;
        default: cur_bin = in_r.sample_2;
      endcase
    end
    ch_on    = (ch_r < chan_cnt_r) && (32'(ch_r) < CHANNELS);
    act      = ch_on && (9'(cur_bin) < 9'(BIN_COUNT));
    cur_addr = ADDR_W'(ch_r) * ADDR_W'(BIN_COUNT) + ADDR_W'(cur_bin);
    inc_val  = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
    cnt_full = act ? ram_rdata : '0;
    cnt_ext  = EXT_W'(cnt_full);
    last_ch  = (ch_r == CHAN_W'(REPORTED - 1));
  end

  // Sequencer: walks the channels of one item through the shared RAM port,
  // multiplier and divider.
  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    clr_addr_nxt  = clr_addr_r;
    in_nxt        = in_r;
    peak_nxt      = peak_r;
    count_nxt     = count_r;
    height_nxt    = height_r;
    prod_nxt      = prod_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = cur_addr;
    ram_wdata     = inc_val;
    div_start     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          in_nxt = in_data;
          ch_nxt = '0;
          case (in_data.mode)
            MODE_PIXEL: state_nxt = ST_PX_RD;
            MODE_QUERY: state_nxt = ST_Q_RD;
            MODE_CLEAR: begin
              state_nxt    = ST_CLR;
              clr_addr_nxt = '0;
              for (int i = 0; i < REPORTED; i++) begin
                peak_nxt[i] = '0;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        end
      end

      ST_PX_RD: begin
        if (act) begin
          ram_re    = 1'b1;
          state_nxt = ST_PX_WR;
        end else if (last_ch) begin
          state_nxt = ST_IDLE;
        end else begin
          ch_nxt = ch_r + CHAN_W'(1);
        end
      end

      ST_PX_WR: begin
        ram_we = 1'b1;
        if (inc_val > peak_r[ch_r]) begin
          peak_nxt[ch_r] = inc_val;
        end
        if (last_ch) begin
          state_nxt = ST_IDLE;
        end else begin
          ch_nxt    = ch_r + CHAN_W'(1);
          state_nxt = ST_PX_RD;
        end
      end

      ST_Q_RD: begin
        ram_re    = act;
        state_nxt = ST_Q_CNT;
      end

      ST_Q_CNT: begin
        count_nxt[ch_r] = cnt_ext[CNT_OUT_W-1:0];
        prod_nxt        = PROD_W'(cnt_full) * PROD_W'(canvas_r);
        state_nxt       = ST_Q_GO;
      end

      ST_Q_GO: begin
        // A zero peak, or a channel that is off, reports a zero height.
        if (act && (peak_r[ch_r] != '0)) begin
          div_start = 1'b1;
          state_nxt = ST_Q_DIV;
        end else begin
          height_nxt[ch_r] = '0;
          state_nxt        = last_ch ? ST_Q_OUT : ST_Q_RD;
          ch_nxt           = last_ch ? ch_r : ch_r + CHAN_W'(1);
        end
      end

      ST_Q_DIV: begin
        if (div_done) begin
          height_nxt[ch_r] = div_quot;
          state_nxt        = last_ch ? ST_Q_OUT : ST_Q_RD;
          ch_nxt           = last_ch ? ch_r : ch_r + CHAN_W'(1);
        end
      end

      ST_Q_OUT: begin
        out_valid_nxt     = 1'b1;
        out_nxt.bin_index = in_r.query_bin;
        out_nxt.count_0   = count_r[0];
        out_nxt.count_1   = count_r[1];
        out_nxt.count_2   = count_r[2];
        out_nxt.height_0  = height_r[0];
        out_nxt.height_1  = height_r[1];
        out_nxt.height_2  = height_r[2];
        state_nxt         = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Reset starts a sweep that zeroes the count store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < REPORTED; i++) begin
        peak_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
      peak_r      <= peak_nxt;
    end
    in_r     <= in_nxt;
    count_r  <= count_nxt;
    height_r <= height_nxt;
    prod_r   <= prod_nxt;
    out_r    <= out_nxt;
  end

  // Configuration registers; the word address picks the register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= RST_CHANNEL_COUNT;
      canvas_r   <= RST_CANVAS_HEIGHT;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_CHANNEL_COUNT) begin
        chan_cnt_r <= pwdata[CHAN_W-1:0];
      end else begin
        canvas_r <= pwdata[HEIGHT_W-1:0];
      end
    end
  end

  assign prdata    = (paddr[2] == REG_CANVAS_HEIGHT) ? 32'(canvas_r) : 32'(chan_cnt_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_reset_sweeps: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("count store sweep did not start after reset");

  a_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.mode != MODE_NONE) |=> busy)
    else $error("accepted item did not make the block busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still working");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_Q_DIV))
    else $error("divider finished outside a height step");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/chps_histogram_check.sv =====
// Scoreboard for the channel histogram core: tracks the bin counts, peaks and
// registers from the observed beats and checks every query result.
// Depends on chps_pkg for the item structs, mode codes and register indexes.
`timescale 1ns / 1ps

module chps_histogram_check
  import chps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        drain_check,
  output int          fails,
  output int          pending,
  output int          pixels_seen,
  output int          queries_seen,
  output int          clears_seen,
  output int          ignored_seen,
  output int          results_seen
);

  localparam logic [CNT_OUT_W-1:0] COUNT_MAX = '1;

  logic [CNT_OUT_W-1:0] bin_tally [REPORTED][256];
  logic [CNT_OUT_W-1:0] peak_tally [REPORTED];
  logic [CHAN_W-1:0]    active_chans;
  logic [HEIGHT_W-1:0]  bar_scale;
  out_item_t            readings_due [$];
  int                   mismatches;
  bit                   drained = 1'b0;

  task automatic empty_store();
    for (int c = 0; c < REPORTED; c++) begin
      peak_tally[c] = '0;
      for (int b = 0; b < 256; b++) bin_tally[c][b] = '0;
    end
  endtask

  task automatic tally_pixel(in_item_t it);
    logic [7:0] value [REPORTED];
    value[0] = it.sample_0;
    value[1] = it.sample_1;
    value[2] = it.sample_2;
    for (int c = 0; c < REPORTED; c++) begin
      if (c < active_chans) begin
        if (bin_tally[c][value[c]] != COUNT_MAX) bin_tally[c][value[c]] += 1'b1;
        if (bin_tally[c][value[c]] > peak_tally[c]) peak_tally[c] = bin_tally[c][value[c]];
      end
    end
  endtask

  // Counts of the bin and their bar heights, scaled so that the peak maps to
  // the full canvas height. Inactive channels read as zero.
  function automatic out_item_t query_reading(logic [7:0] bin);
    out_item_t            r;
    logic [CNT_OUT_W-1:0] cnt [REPORTED];
    logic [HEIGHT_W-1:0]  hgt [REPORTED];
    longint unsigned      scaled;
    for (int c = 0; c < REPORTED; c++) begin
      cnt[c] = '0;
      hgt[c] = '0;
      if (c < active_chans) begin
        cnt[c] = bin_tally[c][bin];
        if (peak_tally[c] != 0) begin
          scaled = (64'(cnt[c]) * 64'(bar_scale)) / 64'(peak_tally[c]);
          hgt[c] = scaled[HEIGHT_W-1:0];
        end
      end
    end
    r.bin_index = bin;
    r.count_0   = cnt[0];
    r.count_1   = cnt[1];
    r.count_2   = cnt[2];
    r.height_0  = hgt[0];
    r.height_1  = hgt[1];
    r.height_2  = hgt[2];
    return r;
  endfunction

  function automatic bit field_differs(string name, longint unsigned want,
                                       longint unsigned got, bit note);
    if (want == got) return 1'b0;
    if (note) $display("  %s: expected %0d, got %0d", name, want, got);
    return 1'b1;
  endfunction

  task automatic check_reading();
    out_item_t want;
    bit        note;
    bit        bad;
    note = (mismatches < 10);
    results_seen++;
    if (readings_due.size() == 0) begin
      if (note) $display("Result for bin %0d at %0t with no query waiting",
                         out_data.bin_index, $realtime);
      mismatches++;
      fails++;
      return;
    end
    want = readings_due.pop_front();
    if (note && want != out_data)
      $display("Result mismatch for bin %0d at %0t:", want.bin_index, $realtime);
    bad = 1'b0;
    bad |= field_differs("bin_index", want.bin_index, out_data.bin_index, note);
    bad |= field_differs("count_0", want.count_0, out_data.count_0, note);
    bad |= field_differs("count_1", want.count_1, out_data.count_1, note);
    bad |= field_differs("count_2", want.count_2, out_data.count_2, note);
    bad |= field_differs("height_0", want.height_0, out_data.height_0, note);
    bad |= field_differs("height_1", want.height_1, out_data.height_1, note);
    bad |= field_differs("height_2", want.height_2, out_data.height_2, note);
    if (bad) begin
      mismatches++;
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      empty_store();
      active_chans = RST_CHANNEL_COUNT;
      bar_scale    = RST_CANVAS_HEIGHT;
      readings_due.delete();
      mismatches   = 0;
    end else begin
      // A result can never stem from a beat taken at the same edge, so the
      // result is checked before the new beat is applied.
      if (out_valid) check_reading();
      if (start && !busy) begin
        case (in_data.mode)
          MODE_PIXEL: begin
            tally_pixel(in_data);
            pixels_seen++;
          end
          MODE_QUERY: begin
            readings_due.push_back(query_reading(in_data.query_bin));
            queries_seen++;
          end
          MODE_CLEAR: begin
            empty_store();
            clears_seen++;
          end
          default: ignored_seen++;
        endcase
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_CHANNEL_COUNT) active_chans = pwdata[CHAN_W-1:0];
        else bar_scale = pwdata[HEIGHT_W-1:0];
      end
      // At the end of the run every query must have been answered.
      if (drain_check && !drained) begin
        drained = 1'b1;
        if (readings_due.size() != 0) begin
          $display("%0d query results never arrived", readings_due.size());
          fails += readings_due.size();
        end
      end
    end
    pending = readings_due.size();
  end

endmodule

// ===== tb/sv/channel_histogram_with_peak_scale_core_test.sv =====
// Top of the histogram core testbench: clock, reset, register writes and item
// stimulus, with the verdict taken from the scoreboard's failure count.
// Depends on chps_pkg, the core and chps_histogram_check.
`timescale 1ns / 1ps

module channel_histogram_with_peak_scale_core_test;
  import chps_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 190;
  // Longest quiet stretch the core can need on its own: a clear sweeps all
  // 768 count entries, so the tail wait covers that with some margin.
  localparam int TAIL_CYCLES = 800;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        start       = 1'b0;
  in_item_t    in_data     = '0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic        drain_check = 1'b0;

  logic        busy;
  logic        out_valid;
  out_item_t   out_data;
  logic [31:0] prdata;
  logic        pready;

  int fails, pending, results_seen;
  int pixels_seen, queries_seen, clears_seen, ignored_seen;

  // Idle insertion on the input side; switched off for one whole phase so
  // that beats also arrive back to back.
  bit         idle_on = 1'b1;
  int         settings_used = 0;
  logic [7:0] hot_base;

  always #(CLK_HALF) clk = ~clk;

  channel_histogram_with_peak_scale_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  chps_histogram_check histo_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .drain_check (drain_check),
    .fails       (fails),
    .pending     (pending),
    .pixels_seen (pixels_seen),
    .queries_seen(queries_seen),
    .clears_seen (clears_seen),
    .ignored_seen(ignored_seen),
    .results_seen(results_seen)
  );

  function automatic in_item_t random_item(logic [1:0] mode);
    in_item_t it;
    it.mode      = mode;
    it.sample_0  = 8'($urandom);
    it.sample_1  = 8'($urandom);
    it.sample_2  = 8'($urandom);
    it.query_bin = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t compose(logic [1:0] mode, logic [7:0] s0, logic [7:0] s1,
                                       logic [7:0] s2, logic [7:0] qb);
    in_item_t it;
    it.mode      = mode;
    it.sample_0  = s0;
    it.sample_1  = s1;
    it.sample_2  = s2;
    it.query_bin = qb;
    return it;
  endfunction

  // Presents one beat and returns at the falling edge after it was taken.
  // Start stays high between beats unless an idle cycle is drawn, so each
  // falling edge sees at most one assignment to start.
  task automatic offer(in_item_t it);
    bit taken;
    if (idle_on) begin
      while ($urandom_range(99) < 27) begin
        start   <= 1'b0;
        in_data <= random_item(2'($urandom));
        @(negedge clk);
      end
    end
    start   <= 1'b1;
    in_data <= it;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end
  endtask

  // Drops start and waits until every query has been answered and the core
  // has finished whatever pixel or clear beat it may still be working on.
  task automatic settle();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  // Setup cycle then access cycle; the write lands on the edge where the
  // access cycle meets pready. Select drops again before the next write.
  task automatic write_reg(logic idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Unused upper bits of the write data are filled with noise; the core
  // must keep only the register's own bits.
  task automatic set_regs(logic [CHAN_W-1:0] chans, logic [HEIGHT_W-1:0] canvas);
    logic [31:0] value;
    settle();
    value = $urandom;
    value[CHAN_W-1:0] = chans;
    write_reg(REG_CHANNEL_COUNT, value);
    value = $urandom;
    value[HEIGHT_W-1:0] = canvas;
    write_reg(REG_CANVAS_HEIGHT, value);
    settings_used++;
  endtask

  // Random traffic under one register setting. Most pixels land in a few
  // neighboring bins so that counts climb and the peak moves, which makes
  // the scaled heights interesting; queries mostly look at those bins too.
  task automatic random_phase(int beats);
    in_item_t it;
    int       sent;
    int       roll;
    hot_base = 8'($urandom);
    sent = 0;
    while (sent < beats) begin
      roll = $urandom_range(999);
      it = random_item(MODE_PIXEL);
      if (roll < 10) begin
        it.mode = MODE_CLEAR;
      end else if (roll < 40) begin
        it.mode = MODE_NONE;
      end else if (roll < 230) begin
        it.mode = MODE_QUERY;
        if ($urandom_range(99) < 65) it.query_bin = 8'(hot_base + $urandom_range(3));
      end else begin
        if ($urandom_range(99) < 70) it.sample_0 = 8'(hot_base + $urandom_range(3));
        if ($urandom_range(99) < 70) it.sample_1 = 8'(hot_base + $urandom_range(3));
        if ($urandom_range(99) < 70) it.sample_2 = 8'(hot_base + $urandom_range(3));
      end
      offer(it);
      if (it.mode != MODE_NONE) sent++;
    end
  endtask

  initial begin
    int chan_plan [PHASES];
    int canvas_plan [PHASES];
    logic [HEIGHT_W-1:0] canvas;

    // A negative canvas entry means a random height for that phase.
    chan_plan   = '{3, 1, 3, 0, 2, 3, 1, 2};
    canvas_plan = '{125, 1023, -1, 1, 0, 1023, -1, -1};

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    // The core sweeps its count store after reset with busy high.
    @(negedge clk);
    while (busy) @(negedge clk);

    // Directed part under the reset settings: a query with every peak still
    // zero, the extreme bins, and an unused mode that must change nothing.
    offer(compose(MODE_QUERY, 8'd0, 8'd0, 8'd0, 8'd0));
    offer(compose(MODE_PIXEL, 8'd0, 8'd255, 8'd128, 8'd17));
    offer(compose(MODE_PIXEL, 8'd0, 8'd255, 8'd7, 8'd0));
    offer(compose(MODE_PIXEL, 8'd255, 8'd0, 8'd128, 8'd255));
    offer(compose(MODE_QUERY, 8'd0, 8'd0, 8'd0, 8'd0));
    offer(compose(MODE_QUERY, 8'd255, 8'd255, 8'd255, 8'd255));
    offer(compose(MODE_QUERY, 8'd1, 8'd2, 8'd3, 8'd128));
    offer(compose(MODE_NONE, 8'd5, 8'd5, 8'd5, 8'd5));
    offer(compose(MODE_QUERY, 8'd0, 8'd0, 8'd0, 8'd5));

    // Grey mode with the tallest canvas: only channel 0 counts and reports.
    set_regs(2'd1, 10'd1023);
    offer(compose(MODE_PIXEL, 8'd200, 8'd200, 8'd200, 8'd0));
    offer(compose(MODE_QUERY, 8'd0, 8'd0, 8'd0, 8'd200));
    offer(compose(MODE_QUERY, 8'd0, 8'd0, 8'd0, 8'd0));

    // No channel active and a zero canvas: everything reads as zero.
    set_regs(2'd0, 10'd0);
    offer(compose(MODE_PIXEL, 8'd9, 8'd9, 8'd9, 8'd9));
    offer(compose(MODE_QUERY, 8'd9, 8'd9, 8'd9, 8'd9));
    offer(compose(MODE_QUERY, 8'd0, 8'd0, 8'd0, 8'd0));

    // Two channels, unit canvas, then a clear that must empty every bin.
    set_regs(2'd2, 10'd1);
    offer(compose(MODE_PIXEL, 8'd255, 8'd255, 8'd255, 8'd0));
    offer(compose(MODE_QUERY, 8'd0, 8'd0, 8'd0, 8'd255));
    offer(compose(MODE_CLEAR, 8'd255, 8'd255, 8'd255, 8'd255));
    offer(compose(MODE_QUERY, 8'd0, 8'd0, 8'd0, 8'd255));
    offer(compose(MODE_QUERY, 8'd0, 8'd0, 8'd0, 8'd0));

    for (int p = 0; p < PHASES; p++) begin
      canvas = (canvas_plan[p] < 0) ? 10'($urandom_range(1023, 1)) : 10'(canvas_plan[p]);
      set_regs(2'(chan_plan[p]), canvas);
      idle_on = (p != 2);
      random_phase(PHASE_BEATS);
    end
    idle_on = 1'b1;

    settle();
    repeat (TAIL_CYCLES) @(negedge clk);
    drain_check <= 1'b1;
    repeat (2) @(negedge clk);

    $display("Covered %0d pixel, %0d query, %0d clear and %0d unused-mode beats",
             pixels_seen, queries_seen, clears_seen, ignored_seen);
    $display("over %0d register settings; %0d query results were checked.",
             settings_used + 1, results_seen);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // A typical run needs under a millisecond, and even a run made only of
  // clears would stay well below this; it only catches a hang.
  initial begin
    #100ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
